// ----- rtl/gle_pkg.sv -----
package gle_pkg;

   localparam int TABLE_SLOTS = 8192;
   localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
   localparam int EPOCH_W     = 8;
   localparam int CODE_W      = 12;
   localparam int FREE_W      = CODE_W + 1;
   localparam int ACC_W       = 24;
   localparam int PEND_W      = 5;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
   localparam logic [FREE_W-1:0]  MAX_CODE    = FREE_W'(4095);
   localparam logic [3:0]         MAX_WIDTH   = 4'd12;
   localparam logic [3:0]         MIN_SIZE_LO = 4'd2;
   localparam logic [3:0]         MIN_SIZE_HI = 4'd8;

   // Dictionary entry; an entry is live only when its epoch matches the current one.
   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [CODE_W-1:0]  prefix;
      logic [7:0]         suffix;
      logic [CODE_W-1:0]  code;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      PUSH_CUR,
      PUSH_CLEAR,
      PUSH_EOI
   } push_sel_type;

   typedef struct packed {
      logic         accept;
      logic         start_image;
      logic         push;
      push_sel_type push_sel;
      logic         final_set;
      logic         emit;
      logic         flush_emit;
      logic         finish;
      logic         probe_next;
      logic         insert;
      logic         restart;
      logic         cur_from_pix;
      logic         cur_from_hit;
      logic         wipe;
      logic         sweep_write;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic last;
      logic out_free;
      logic pend_ge8;
      logic pend_nz;
      logic hit;
      logic live;
      logic room;
      logic epoch_max;
      logic sweep_done;
   } sts_type;

endpackage

// ----- rtl/gle_ram.sv -----
module gle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gle_ctrl.sv -----
module gle_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  gle_pkg::sts_type sts,
   output gle_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_START,
      ST_CLEARCODE,
      ST_PROBE_RD,
      ST_PROBE_CMP,
      ST_MISS,
      ST_RESTART,
      ST_LAST,
      ST_EOI,
      ST_FLUSH,
      ST_DRAIN,
      ST_WIPE
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      cmd.push_sel = gle_pkg::PUSH_CUR;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (sts.sweep_done) begin
               state_in = ret_ff;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = sts.active ? ST_PROBE_RD : ST_START;
            end
         end
         ST_START: begin
            cmd.start_image = 1'b1;
            ret_in   = ST_CLEARCODE;
            state_in = ST_WIPE;
         end
         ST_CLEARCODE: begin
            cmd.push         = 1'b1;
            cmd.push_sel     = gle_pkg::PUSH_CLEAR;
            cmd.cur_from_pix = 1'b1;
            ret_in   = ST_LAST;
            state_in = ST_DRAIN;
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CMP;
         end
         ST_PROBE_CMP: begin
            if (sts.hit) begin
               cmd.cur_from_hit = 1'b1;
               state_in = ST_LAST;
            end else if (sts.live) begin
               cmd.probe_next = 1'b1;
               state_in = ST_PROBE_RD;
            end else begin
               cmd.push = 1'b1;
               ret_in   = ST_MISS;
               state_in = ST_DRAIN;
            end
         end
         ST_MISS: begin
            if (sts.room) begin
               cmd.insert       = 1'b1;
               cmd.cur_from_pix = 1'b1;
               state_in = ST_LAST;
            end else begin
               cmd.push     = 1'b1;
               cmd.push_sel = gle_pkg::PUSH_CLEAR;
               ret_in   = ST_RESTART;
               state_in = ST_DRAIN;
            end
         end
         ST_RESTART: begin
            cmd.restart      = 1'b1;
            cmd.cur_from_pix = 1'b1;
            ret_in   = ST_LAST;
            state_in = ST_WIPE;
         end
         ST_LAST: begin
            if (sts.last) begin
               cmd.push = 1'b1;
               ret_in   = ST_EOI;
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EOI: begin
            cmd.push      = 1'b1;
            cmd.push_sel  = gle_pkg::PUSH_EOI;
            cmd.final_set = 1'b1;
            ret_in   = ST_FLUSH;
            state_in = ST_DRAIN;
         end
         ST_FLUSH: begin
            if (!sts.pend_nz) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush_emit = 1'b1;
               cmd.finish     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (!sts.pend_ge8) begin
               state_in = ret_ff;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
            end
         end
         ST_WIPE: begin
            cmd.wipe = 1'b1;
            state_in = sts.epoch_max ? ST_SWEEP : ret_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// ----- rtl/gle_dp.sv -----
module gle_dp (
   input  logic             clock,
   input  logic             reset,
   input  gle_pkg::cmd_type cmd,
   output gle_pkg::sts_type sts,
   input  logic [7:0]       req_pixel_index,
   input  logic             req_last_pixel,
   input  logic             csr_valid,
   input  logic [3:0]       csr_min_code_size,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last_byte
);

   localparam int AW = gle_pkg::SLOT_AW;

   logic [3:0]                   min_ff, min_in;
   logic [3:0]                   imin_ff, imin_in;
   logic [3:0]                   cw_ff, cw_in;
   logic [gle_pkg::FREE_W-1:0]   nf_ff, nf_in;
   logic [gle_pkg::CODE_W-1:0]   cur_ff, cur_in;
   logic [7:0]                   pix_ff, pix_in;
   logic                         last_ff, last_in;
   logic                         active_ff, active_in;
   logic [gle_pkg::EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [gle_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [gle_pkg::PEND_W-1:0]   pend_ff, pend_in;
   logic                         final_ff, final_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic                         ovalid_ff, ovalid_in;
   logic [7:0]                   odata_ff, odata_in;
   logic                         olast_ff, olast_in;

   logic [3:0]                   clamp;
   logic [gle_pkg::CODE_W-1:0]   clear_code;
   logic [7:0]                   pix_mask;
   logic [7:0]                   suffix;
   logic [7:0]                   req_suffix;
   logic [19:0]                  hash;
   logic [gle_pkg::CODE_W-1:0]   push_code;
   gle_pkg::entry_type           rd_entry;
   gle_pkg::entry_type           wr_entry;
   logic [gle_pkg::ENTRY_W-1:0]  rd_word;
   logic                         wr_en;
   logic                         out_free;

   always_comb begin
      if (min_ff < gle_pkg::MIN_SIZE_LO) begin
         clamp = gle_pkg::MIN_SIZE_LO;
      end else if (min_ff > gle_pkg::MIN_SIZE_HI) begin
         clamp = gle_pkg::MIN_SIZE_HI;
      end else begin
         clamp = min_ff;
      end
   end

   assign clear_code = gle_pkg::CODE_W'(1) << imin_ff;
   assign pix_mask   = 8'(clear_code - gle_pkg::CODE_W'(1));
   assign suffix     = pix_ff & pix_mask;
   assign req_suffix = req_pixel_index & pix_mask;
   assign hash       = {cur_ff, 8'h00} ^ {12'h000, req_suffix};
   assign rd_entry   = gle_pkg::entry_type'(rd_word);
   assign out_free   = !ovalid_ff || rsp_ready;

   always_comb begin
      case (cmd.push_sel)
         gle_pkg::PUSH_CUR:   push_code = cur_ff;
         gle_pkg::PUSH_CLEAR: push_code = clear_code;
         gle_pkg::PUSH_EOI:   push_code = clear_code + gle_pkg::CODE_W'(1);
         default:             push_code = cur_ff;
      endcase
   end

   always_comb begin
      wr_entry        = '0;
      wr_entry.epoch  = epoch_ff;
      wr_entry.prefix = cur_ff;
      wr_entry.suffix = suffix;
      wr_entry.code   = nf_ff[gle_pkg::CODE_W-1:0];
      if (cmd.sweep_write) begin
         wr_entry.epoch = '0;
      end
   end

   assign wr_en = cmd.insert || cmd.sweep_write;

   gle_ram #(
      .WIDTH (gle_pkg::ENTRY_W),
      .DEPTH (gle_pkg::TABLE_SLOTS)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   always_comb begin
      min_in    = min_ff;
      imin_in   = imin_ff;
      cw_in     = cw_ff;
      nf_in     = nf_ff;
      cur_in    = cur_ff;
      pix_in    = pix_ff;
      last_in   = last_ff;
      active_in = active_ff;
      epoch_in  = epoch_ff;
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      final_in  = final_ff;
      addr_in   = addr_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      odata_in  = odata_ff;
      olast_in  = olast_ff;

      if (csr_valid) begin
         min_in = csr_min_code_size;
      end
      if (cmd.accept) begin
         pix_in  = req_pixel_index;
         last_in = req_last_pixel;
         addr_in = hash[AW-1:0];
      end
      if (cmd.start_image) begin
         imin_in   = clamp;
         nf_in     = (gle_pkg::FREE_W'(1) << clamp) + gle_pkg::FREE_W'(2);
         cw_in     = clamp + 4'd1;
         acc_in    = '0;
         pend_in   = '0;
         active_in = 1'b1;
      end
      if (cmd.push) begin
         acc_in  = acc_ff | (gle_pkg::ACC_W'(push_code) << pend_ff);
         pend_in = pend_ff + gle_pkg::PEND_W'(cw_ff);
      end
      if (cmd.final_set) begin
         final_in = 1'b1;
      end
      if (cmd.emit) begin
         ovalid_in = 1'b1;
         odata_in  = acc_ff[7:0];
         olast_in  = final_ff && (pend_ff == gle_pkg::PEND_W'(8));
         acc_in    = acc_ff >> 8;
         pend_in   = pend_ff - gle_pkg::PEND_W'(8);
      end
      if (cmd.flush_emit) begin
         ovalid_in = 1'b1;
         odata_in  = acc_ff[7:0];
         olast_in  = 1'b1;
      end
      if (cmd.finish) begin
         acc_in    = '0;
         pend_in   = '0;
         active_in = 1'b0;
         final_in  = 1'b0;
      end
      if (cmd.probe_next) begin
         addr_in = addr_ff + AW'(1);
      end
      if (cmd.insert) begin
         if ((nf_ff >> cw_ff) != '0 && cw_ff < gle_pkg::MAX_WIDTH) begin
            cw_in = cw_ff + 4'd1;
         end
         nf_in = nf_ff + gle_pkg::FREE_W'(1);
      end
      if (cmd.restart) begin
         nf_in = (gle_pkg::FREE_W'(1) << imin_ff) + gle_pkg::FREE_W'(2);
         cw_in = imin_ff + 4'd1;
      end
      if (cmd.cur_from_pix) begin
         // start the image's first string or a new string after a miss
         cur_in = gle_pkg::CODE_W'(cmd.start_image ? (pix_ff & pix_mask) : suffix);
      end
      if (cmd.cur_from_hit) begin
         cur_in = rd_entry.code;
      end
      if (cmd.wipe) begin
         // on epoch wrap, go through the table once before reuse
         if (epoch_ff == gle_pkg::EPOCH_LAST) begin
            epoch_in = gle_pkg::EPOCH_FIRST;
            addr_in  = '0;
         end else begin
            epoch_in = epoch_ff + gle_pkg::EPOCH_W'(1);
         end
      end
      if (cmd.sweep_write) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= gle_pkg::MIN_SIZE_LO;
         imin_ff   <= gle_pkg::MIN_SIZE_LO;
         cw_ff     <= 4'd3;
         nf_ff     <= gle_pkg::FREE_W'(6);
         cur_ff    <= '0;
         active_ff <= 1'b0;
         epoch_ff  <= gle_pkg::EPOCH_FIRST;
         acc_ff    <= '0;
         pend_ff   <= '0;
         final_ff  <= 1'b0;
         addr_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         min_ff    <= min_in;
         imin_ff   <= imin_in;
         cw_ff     <= cw_in;
         nf_ff     <= nf_in;
         cur_ff    <= cur_in;
         active_ff <= active_in;
         epoch_ff  <= epoch_in;
         acc_ff    <= acc_in;
         pend_ff   <= pend_in;
         final_ff  <= final_in;
         addr_ff   <= addr_in;
         ovalid_ff <= ovalid_in;
      end
      pix_ff   <= pix_in;
      last_ff  <= last_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
   end

   always_comb begin
      sts.active     = active_ff;
      sts.last       = last_ff;
      sts.out_free   = out_free;
      sts.pend_ge8   = pend_ff >= gle_pkg::PEND_W'(8);
      sts.pend_nz    = pend_ff != '0;
      sts.live       = rd_entry.epoch == epoch_ff;
      sts.hit        = sts.live && rd_entry.prefix == cur_ff && rd_entry.suffix == suffix;
      sts.room       = nf_ff <= gle_pkg::MAX_CODE;
      sts.epoch_max  = epoch_ff == gle_pkg::EPOCH_LAST;
      sts.sweep_done = &addr_ff;
   end

   assign rsp_valid     = ovalid_ff;
   assign rsp_data_byte = odata_ff;
   assign rsp_last_byte = olast_ff;

endmodule

// ----- rtl/gif_lzw_encoder.sv -----
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req_pixel_index, req_last_pixel
// rsp      out        rsp_valid, rsp_ready, rsp_data_byte, rsp_last_byte
// csr      in         csr_valid, csr_ready, csr_min_code_size
//
// One pixel at a time: a dictionary hit takes one registered read of the dictionary
// RAM per probe; a miss also waits while each complete output byte is sent.
// Bytes leave through a single output register.
// After reset, and after every 255 dictionary wipes, a pass over all TABLE_SLOTS
// (8192) entries marks them stale; no pixel is taken meanwhile.
// A stalled rsp side holds the byte sequencer; csr writes are always taken.
module gif_lzw_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel_index,
   input  logic       req_last_pixel,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_min_code_size
);

   gle_pkg::cmd_type cmd;
   gle_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   gle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gle_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_pixel_index   (req_pixel_index),
      .req_last_pixel    (req_last_pixel),
      .csr_valid         (csr_valid),
      .csr_min_code_size (csr_min_code_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_byte     (rsp_last_byte)
   );

endmodule
